FILE: hdl/wtt_pkg.sv
// Shared types and codes of the weight-throwing termination node.
`default_nettype none
package wtt_pkg;

  localparam int unsigned WeightW = 64;
  localparam int unsigned CfgIdxW = 3;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RECV  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_APP  = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_FWD  = 2'd2;
  localparam logic [1:0] KIND_TERM = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_OWN_ID    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IS_COORD  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_ACT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEND_LIM  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EXP_WGT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE = 3'd5;

  localparam logic [23:0] TOLERANCE_RST = 24'd3355443;

  typedef struct packed {
    logic [7:0]         own_node_id;
    logic               is_coordinator;
    logic               start_active;
    logic [31:0]        total_send_limit;
    logic [WeightW-1:0] expected_total_weight;
    logic [23:0]        match_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         sender_id;
    logic               msg_is_control;
    logic [WeightW-1:0] msg_weight;
    logic [3:0]         chosen_neighbour;
    logic [15:0]        phase_quota;
  } item_t;

  typedef struct packed {
    logic [1:0]         message_kind;
    logic [3:0]         neighbour_index;
    logic [7:0]         origin_id;
    logic [WeightW-1:0] weight_out;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage
`default_nettype wire

FILE: hdl/weight_throwing_termination_node.sv
// Top level of the weight-throwing termination node.
// An accepted beat is registered in the input register, processed there by the core,
// and its results are written into the output buffer when the item fires.
// Throughput: one item per cycle while the buffer has room; two results need two
// output beats and hold back the next item; output stalls back up into the input.
// Reset: node passive with zero weight and counters, config zero, tolerance 3355443.
`default_nettype none
module weight_throwing_termination_node #(
  parameter int unsigned MAX_NEIGHBOURS       = 12,
  parameter int unsigned WEIGHT_FRACTION_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output wire logic        in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  sender_id_i,
  input  wire logic        msg_is_control_i,
  input  wire logic [63:0] msg_weight_i,
  input  wire logic [3:0]  chosen_neighbour_i,
  input  wire logic [15:0] phase_quota_i,
  output wire logic        out_valid_o,
  input  wire logic        out_ready_i,
  output wire logic [1:0]  message_kind_o,
  output wire logic [3:0]  neighbour_index_o,
  output wire logic [7:0]  origin_id_o,
  output wire logic [63:0] weight_out_o,
  output wire logic        last_of_run_o
);
  import wtt_pkg::*;

  cfg_t         cfg;
  item_t        item_q;
  logic         in_valid_q;
  logic         fire, room;
  result_pair_t res;
  result_t      out_res;

  wtt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input stage
  assign fire       = in_valid_q && (room || res.count == 2'd0);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{func_i, sender_id_i, msg_is_control_i, msg_weight_i,
                  chosen_neighbour_i, phase_quota_i};
    end
  end

  wtt_node_core #(
    .MAX_NEIGHBOURS       (MAX_NEIGHBOURS),
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .fire_i (fire),
    .res_o  (res)
  );

  wtt_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign message_kind_o    = out_res.message_kind;
  assign neighbour_index_o = out_res.neighbour_index;
  assign origin_id_o       = out_res.origin_id;
  assign weight_out_o      = out_res.weight_out;
  assign last_of_run_o     = out_res.last_of_run;

endmodule
`default_nettype wire

FILE: hdl/wtt_cfg_regs.sv
// Configuration register file of the termination node.
`default_nettype none
module wtt_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [wtt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wtt_pkg::WeightW-1:0] cfg_wdata_i,
  output wtt_pkg::cfg_t                    cfg_o
);
  import wtt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ID:    cfg_d.own_node_id           = cfg_wdata_i[7:0];
        CFG_IS_COORD:  cfg_d.is_coordinator        = cfg_wdata_i[0];
        CFG_START_ACT: cfg_d.start_active          = cfg_wdata_i[0];
        CFG_SEND_LIM:  cfg_d.total_send_limit      = cfg_wdata_i[31:0];
        CFG_EXP_WGT:   cfg_d.expected_total_weight = cfg_wdata_i;
        CFG_TOLERANCE: cfg_d.match_tolerance       = cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_node_id:           8'd0,
                 is_coordinator:        1'b0,
                 start_active:          1'b0,
                 total_send_limit:      32'd0,
                 expected_total_weight: '0,
                 match_tolerance:       TOLERANCE_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/wtt_node_core.sv
// Node state and single-pass step logic: computes the results of one item.
`default_nettype none
module wtt_node_core #(
  parameter int unsigned MAX_NEIGHBOURS       = 12,
  parameter int unsigned WEIGHT_FRACTION_BITS = 24
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wtt_pkg::cfg_t        cfg_i,
  input  wtt_pkg::item_t       item_i,
  input  wire logic            fire_i,
  output wtt_pkg::result_pair_t res_o
);
  import wtt_pkg::*;

  localparam logic [WeightW-1:0] InitWeight =
    WeightW'(64'd1 << (30 + WEIGHT_FRACTION_BITS));

  // neighbour index wrap table, one nibble per 4-bit input value
  function automatic logic [63:0] nb_lut();
    logic [63:0] lut;
    lut = '0;
    for (int i = 0; i < 16; i++) lut[i*4 +: 4] = 4'(i % MAX_NEIGHBOURS);
    return lut;
  endfunction

  localparam logic [63:0] NbLut = nb_lut();

  logic               active_q, active_d;
  logic [WeightW-1:0] weight_q, weight_d;
  logic [15:0]        psends_q, psends_d;
  logic [15:0]        target_q, target_d;
  logic [31:0]        tsends_q, tsends_d;

  logic [3:0]         nb_mod;
  logic [15:0]        quota_eff;
  logic [WeightW-1:0] thrown, keep, sum_sat, wsel;
  logic [WeightW:0]   sum_w, diff_w;
  logic [WeightW-1:0] wdist;
  logic               win_ok;
  logic [15:0]        psends_inc;
  logic [31:0]        tsends_inc;
  logic               stop;
  result_t            r_app, r_ctrl, r_term, r_fwd;
  result_pair_t       res;

  assign nb_mod    = NbLut[{item_i.chosen_neighbour, 2'b00} +: 4];
  assign quota_eff = (item_i.phase_quota == '0) ? 16'd1 : item_i.phase_quota;

  assign thrown  = weight_q >> 1;
  assign keep    = weight_q - thrown;
  assign sum_w   = {1'b0, weight_q} + {1'b0, item_i.msg_weight};
  assign sum_sat = sum_w[WeightW] ? '1 : sum_w[WeightW-1:0];

  always_comb begin
    case (item_i.func)
      FUNC_RECV: wsel = sum_sat;
      default:   wsel = active_q ? keep : weight_q;
    endcase
  end

  // termination window test on the weight the item leaves behind
  assign diff_w = {1'b0, wsel} - {1'b0, cfg_i.expected_total_weight};
  assign wdist  = diff_w[WeightW] ? (~diff_w[WeightW-1:0] + 1'b1) : diff_w[WeightW-1:0];
  assign win_ok = wdist <= WeightW'(cfg_i.match_tolerance);

  assign psends_inc = (psends_q == '1) ? psends_q : psends_q + 16'd1;
  assign tsends_inc = (tsends_q == '1) ? tsends_q : tsends_q + 32'd1;
  assign stop       = (psends_inc == target_q) || (tsends_inc >= cfg_i.total_send_limit);

  always_comb begin
    r_app  = '{KIND_APP,  nb_mod, cfg_i.own_node_id, thrown, 1'b0};
    r_ctrl = '{KIND_CTRL, 4'd0, cfg_i.own_node_id, wsel, 1'b0};
    r_term = '{KIND_TERM, 4'd0, cfg_i.own_node_id, wsel, 1'b0};
    r_fwd  = '{KIND_FWD,  4'd0, item_i.sender_id, item_i.msg_weight, 1'b0};
  end

  always_comb begin
    active_d = active_q;
    weight_d = weight_q;
    psends_d = psends_q;
    target_d = target_q;
    tsends_d = tsends_q;
    res      = '0;
    case (item_i.func)
      FUNC_START: begin
        active_d = cfg_i.start_active;
        weight_d = cfg_i.start_active ? InitWeight : '0;
        psends_d = '0;
        tsends_d = '0;
        target_d = quota_eff;
      end
      FUNC_TICK: begin
        if (active_q) begin
          weight_d   = keep;
          psends_d   = psends_inc;
          tsends_d   = tsends_inc;
          res.res0   = r_app;
          res.count  = 2'd1;
          if (stop) begin
            active_d = 1'b0;
            if (cfg_i.is_coordinator) begin
              if (win_ok) begin
                res.res1  = r_term;
                res.count = 2'd2;
              end
            end else begin
              res.res1  = r_ctrl;
              res.count = 2'd2;
              weight_d  = '0;
            end
          end
        end else if (weight_q != '0) begin
          if (cfg_i.is_coordinator) begin
            if (win_ok) begin
              res.res0  = r_term;
              res.count = 2'd1;
            end
          end else begin
            res.res0  = r_ctrl;
            res.count = 2'd1;
            weight_d  = '0;
          end
        end
      end
      FUNC_RECV: begin
        if (item_i.msg_is_control && !cfg_i.is_coordinator) begin
          res.res0  = r_fwd;
          res.count = 2'd1;
        end else begin
          weight_d = sum_sat;
          if (!active_q && (tsends_q < cfg_i.total_send_limit)) begin
            active_d = 1'b1;
            psends_d = '0;
            target_d = quota_eff;
          end else if (!active_q && cfg_i.is_coordinator && win_ok) begin
            res.res0  = r_term;
            res.count = 2'd1;
          end
        end
      end
      default: ;
    endcase
    case (res.count)
      2'd1:    res.res0.last_of_run = 1'b1;
      2'd2:    res.res1.last_of_run = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      weight_q <= '0;
      psends_q <= '0;
      target_q <= '0;
      tsends_q <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      weight_q <= weight_d;
      psends_q <= psends_d;
      target_q <= target_d;
      tsends_q <= tsends_d;
    end
  end

  assign res_o = res;

  a_two_starts_with_app: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.count == 2'd2 |-> res.res0.message_kind == KIND_APP)
    else $error("second result without a leading application send");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.func == FUNC_START |=> psends_q == '0 && tsends_q == '0 && target_q != '0)
    else $error("start did not reset counters");

  a_ctrl_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.count != 2'd0 && !cfg_i.is_coordinator &&
    (res.res0.message_kind == KIND_CTRL || res.res1.message_kind == KIND_CTRL)
    |=> weight_q == '0 && !active_q)
    else $error("weight kept after control send");

endmodule
`default_nettype wire

FILE: hdl/wtt_result_buf.sv
// Two-entry result buffer that serializes up to two results per item.
`default_nettype none
module wtt_result_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wtt_pkg::result_pair_t res_i,
  output wire logic             room_o,
  output wire logic             out_valid_o,
  input  wire logic             out_ready_i,
  output wtt_pkg::result_t      out_o
);
  import wtt_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    s0_q, s0_d, s1_q, s1_d;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign out_o       = s0_q;

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (push_i && res_i.count != 2'd0) begin
      s0_d  = res_i.res0;
      s1_d  = res_i.res1;
      cnt_d = res_i.count;
    end else if (pop) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer overfilled");

  a_pair_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !s0_q.last_of_run && s1_q.last_of_run)
    else $error("result pair marked wrong");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && res_i.count != 2'd0 |-> room_o)
    else $error("push without room");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Testbench for the weight-throwing termination node: directed and random beats checked in order.
module testbench;
  import wtt_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [63:0] INIT_WEIGHT = 64'd1 << (30 + 24);
  localparam int unsigned NEIGHBOURS  = 12;

  class emission_tracker;
    logic [7:0]  own_id;
    logic        coord;
    logic        start_act;
    logic [31:0] send_lim;
    logic [63:0] exp_w;
    logic [23:0] tol;
    logic        active;
    logic [63:0] held;
    logic [15:0] phase_sends;
    logic [15:0] phase_target;
    logic [31:0] total_sends;
    result_t     due[$];
    int          errors;
    int          items;
    int          kind_seen[4];

    function new();
      own_id = '0;
      coord = 1'b0;
      start_act = 1'b0;
      send_lim = '0;
      exp_w = '0;
      tol = TOLERANCE_RST;
      active = 1'b0;
      held = '0;
      phase_sends = '0;
      phase_target = '0;
      total_sends = '0;
      errors = 0;
      items = 0;
      kind_seen = '{0, 0, 0, 0};
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        CFG_OWN_ID:    own_id = v[7:0];
        CFG_IS_COORD:  coord = v[0];
        CFG_START_ACT: start_act = v[0];
        CFG_SEND_LIM:  send_lim = v[31:0];
        CFG_EXP_WGT:   exp_w = v;
        CFG_TOLERANCE: tol = v[23:0];
        default: ;
      endcase
    endfunction

    function bit in_window();
      logic [63:0] d;
      d = (held >= exp_w) ? held - exp_w : exp_w - held;
      return d <= {40'd0, tol};
    endfunction

    function void emit(logic [1:0] kind, logic [3:0] nb, logic [7:0] origin, logic [63:0] w);
      result_t r;
      r.message_kind = kind;
      r.neighbour_index = nb;
      r.origin_id = origin;
      r.weight_out = w;
      r.last_of_run = 1'b0;
      due = {due, r};
    endfunction

    // passive node holding weight: coordinator tests, others hand weight to parent
    function void release_weight();
      if (coord) begin
        if (in_window()) emit(KIND_TERM, 4'd0, own_id, held);
      end else begin
        emit(KIND_CTRL, 4'd0, own_id, held);
        held = '0;
      end
    endfunction

    function void note_item(item_t it);
      int          before_cnt;
      logic [3:0]  nb;
      logic [63:0] thrown;
      logic [64:0] sum;
      before_cnt = due.size();
      nb = 4'(it.chosen_neighbour % NEIGHBOURS);
      items++;
      case (it.func)
        FUNC_START: begin
          active = start_act;
          held = start_act ? INIT_WEIGHT : 64'd0;
          phase_sends = '0;
          total_sends = '0;
          phase_target = (it.phase_quota == 16'd0) ? 16'd1 : it.phase_quota;
        end
        FUNC_TICK: begin
          if (!active) begin
            if (held != 64'd0) release_weight();
          end else begin
            thrown = held >> 1;
            held = held - thrown;
            emit(KIND_APP, nb, own_id, thrown);
            if (phase_sends != 16'hFFFF) phase_sends++;
            if (total_sends != 32'hFFFF_FFFF) total_sends++;
            if (phase_sends == phase_target || total_sends >= send_lim) begin
              active = 1'b0;
              release_weight();
            end
          end
        end
        FUNC_RECV: begin
          if (it.msg_is_control && !coord) begin
            emit(KIND_FWD, 4'd0, it.sender_id, it.msg_weight);
          end else begin
            sum = {1'b0, held} + {1'b0, it.msg_weight};
            held = sum[64] ? '1 : sum[63:0];
            if (!active && total_sends < send_lim) begin
              active = 1'b1;
              phase_sends = '0;
              phase_target = (it.phase_quota == 16'd0) ? 16'd1 : it.phase_quota;
            end
            if (coord && !active && in_window()) emit(KIND_TERM, 4'd0, own_id, held);
          end
        end
        default: ;
      endcase
      if (due.size() > before_cnt) begin
        due[due.size() - 1].last_of_run = 1'b1;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected beat kind=%0d nb=%0d origin=%0d w=%h last=%0b",
                   got.message_kind, got.neighbour_index, got.origin_id, got.weight_out,
                   got.last_of_run);
        return;
      end
      want = due.pop_front();
      if (got.message_kind !== want.message_kind ||
          got.neighbour_index !== want.neighbour_index ||
          got.origin_id !== want.origin_id ||
          got.weight_out !== want.weight_out ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp kind=%0d nb=%0d origin=%0d w=%h last=%0b",
                   want.message_kind, want.neighbour_index, want.origin_id,
                   want.weight_out, want.last_of_run);
          $display("       got kind=%0d nb=%0d origin=%0d w=%h last=%0b",
                   got.message_kind, got.neighbour_index, got.origin_id,
                   got.weight_out, got.last_of_run);
        end
      end else begin
        kind_seen[got.message_kind]++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func = '0;
  logic [7:0]  sender_id = '0;
  logic        msg_is_control = 1'b0;
  logic [63:0] msg_weight = '0;
  logic [3:0]  chosen_neighbour = '0;
  logic [15:0] phase_quota = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  message_kind_o;
  logic [3:0]  neighbour_index_o;
  logic [7:0]  origin_id_o;
  logic [63:0] weight_out_o;
  logic        last_of_run_o;

  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  quiet = 1'b0;
  int  setups = 0;
  emission_tracker sb;

  weight_throwing_termination_node dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .func_i            (func),
    .sender_id_i       (sender_id),
    .msg_is_control_i  (msg_is_control),
    .msg_weight_i      (msg_weight),
    .chosen_neighbour_i(chosen_neighbour),
    .phase_quota_i     (phase_quota),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .message_kind_o    (message_kind_o),
    .neighbour_index_o (neighbour_index_o),
    .origin_id_o       (origin_id_o),
    .weight_out_o      (weight_out_o),
    .last_of_run_o     (last_of_run_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_valid_o && out_ready) begin
      seen.message_kind = message_kind_o;
      seen.neighbour_index = neighbour_index_o;
      seen.origin_id = origin_id_o;
      seen.weight_out = weight_out_o;
      seen.last_of_run = last_of_run_o;
      sb.check_result(seen);
    end
  end

  // receiver side: random stall bursts on out_ready
  initial begin
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 10);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic item_t pack_item(logic [1:0] f, logic [7:0] snd, logic ctl,
                                      logic [63:0] w, logic [3:0] nb, logic [15:0] q);
    item_t it;
    it.func = f;
    it.sender_id = snd;
    it.msg_is_control = ctl;
    it.msg_weight = w;
    it.chosen_neighbour = nb;
    it.phase_quota = q;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    func = it.func;
    sender_id = it.sender_id;
    msg_is_control = it.msg_is_control;
    msg_weight = it.msg_weight;
    chosen_neighbour = it.chosen_neighbour;
    phase_quota = it.phase_quota;
    do @(posedge clk); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    item_t       it;
    int          pick;
    logic [63:0] w;
    logic [63:0] delta;
    logic [15:0] q;
    sb = new();
    gap_pct = 20;
    stall_pct = 20;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: passive node, zero send limit
    setups++;
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd0, 16'd1));
    send_item(pack_item(FUNC_UNUSED, 8'hFF, 1'b1, '1, 4'hF, 16'hFFFF));
    send_item(pack_item(FUNC_START, 8'd0, 1'b0, 64'd0, 4'd0, 16'd0));
    send_item(pack_item(FUNC_RECV, 8'd7, 1'b0, 64'h1_0000_0000, 4'd0, 16'd2));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd3, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'hFF, 1'b1, '1, 4'd0, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'd0, 1'b1, 64'd0, 4'd0, 16'd1));
    settle();

    // plain node, no limit, zero tolerance
    setups++;
    write_reg(CFG_OWN_ID, 64'hFF);
    write_reg(CFG_IS_COORD, 64'd0);
    write_reg(CFG_START_ACT, 64'd1);
    write_reg(CFG_SEND_LIM, 64'hFFFF_FFFF);
    write_reg(CFG_EXP_WGT, 64'd0);
    write_reg(CFG_TOLERANCE, 64'd0);
    send_item(pack_item(FUNC_START, 8'd0, 1'b0, 64'd0, 4'd0, 16'd0));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd15, 16'd1));
    send_item(pack_item(FUNC_START, 8'd0, 1'b0, 64'd0, 4'd0, 16'd3));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd11, 16'd1));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd12, 16'd1));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd0, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'd1, 1'b0, '1, 4'd0, 16'hFFFF));
    send_item(pack_item(FUNC_RECV, 8'd2, 1'b0, '1, 4'd0, 16'hFFFF));
    send_item(pack_item(FUNC_RECV, 8'hAA, 1'b1, 64'h8000_0000_0000_0000, 4'd0, 16'd1));
    settle();

    // coordinator: limit of one, widest tolerance, then limit zero
    setups++;
    write_reg(CFG_OWN_ID, 64'h5A);
    write_reg(CFG_IS_COORD, 64'd1);
    write_reg(CFG_SEND_LIM, 64'd1);
    write_reg(CFG_EXP_WGT, INIT_WEIGHT);
    write_reg(CFG_TOLERANCE, 64'hFF_FFFF);
    send_item(pack_item(FUNC_START, 8'd0, 1'b0, 64'd0, 4'd0, 16'hFFFF));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd6, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'd9, 1'b0, INIT_WEIGHT >> 1, 4'd0, 16'd1));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd0, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'd9, 1'b1, 64'd0, 4'd0, 16'd1));
    settle();
    write_reg(CFG_SEND_LIM, 64'd0);
    send_item(pack_item(FUNC_START, 8'd0, 1'b0, 64'd0, 4'd0, 16'd5));
    send_item(pack_item(FUNC_TICK, 8'd0, 1'b0, 64'd0, 4'd1, 16'd1));
    send_item(pack_item(FUNC_RECV, 8'd3, 1'b0, 64'd1, 4'd0, 16'd4));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      setups++;
      quiet = (ph == 7);
      pick = $urandom_range(0, 2);
      gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      pick = $urandom_range(0, 2);
      stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      write_reg(CFG_OWN_ID, 64'($urandom_range(0, 255)));
      write_reg(CFG_IS_COORD, 64'(ph % 2));
      write_reg(CFG_START_ACT, 64'($urandom_range(0, 4) != 0));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_SEND_LIM, 64'd0);
        1: write_reg(CFG_SEND_LIM, 64'd1);
        2: write_reg(CFG_SEND_LIM, 64'($urandom_range(2, 40)));
        3: write_reg(CFG_SEND_LIM, 64'($urandom_range(100, 5000)));
        4: write_reg(CFG_SEND_LIM, 64'hFFFF_FFFF);
        default: write_reg(CFG_SEND_LIM, 64'($urandom));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_EXP_WGT, 64'd0);
        1: write_reg(CFG_EXP_WGT, '1);
        2: write_reg(CFG_EXP_WGT, {$urandom, $urandom});
        default: write_reg(CFG_EXP_WGT, INIT_WEIGHT * $urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_TOLERANCE, 64'd0);
        1: write_reg(CFG_TOLERANCE, 64'(TOLERANCE_RST));
        2: write_reg(CFG_TOLERANCE, 64'hFF_FFFF);
        default: write_reg(CFG_TOLERANCE, 64'($urandom_range(0, 24'hFF_FFFF)));
      endcase

      send_item(pack_item(FUNC_START, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                          4'($urandom), 16'($urandom_range(1, 8))));
      for (int n = 0; n < 250; n++) begin
        case ($urandom_range(0, 9))
          0: w = ($urandom_range(0, 1) != 0) ? '1 : 64'd1 << $urandom_range(0, 63);
          1: w = 64'd0;
          2, 3, 4: w = {$urandom, $urandom};
          5, 6: w = INIT_WEIGHT >> $urandom_range(0, 40);
          default: begin
            // lands near the coordinator's expected total, both edges of the window
            delta = 64'($urandom_range(0, 2 * int'(sb.tol) + 2)) - 64'(sb.tol) - 64'd1;
            w = sb.exp_w - sb.held + delta;
          end
        endcase
        case ($urandom_range(0, 5))
          0: q = 16'd0;
          1: q = 16'hFFFF;
          2: q = 16'($urandom);
          default: q = 16'($urandom_range(1, 8));
        endcase
        pick = $urandom_range(0, 99);
        it = pack_item(FUNC_RECV, 8'($urandom), ($urandom_range(0, 2) == 0), w,
                       4'($urandom), q);
        if (pick < 4) it.func = FUNC_UNUSED;
        else if (pick < 8) it.func = FUNC_START;
        else if (pick < 55) it.func = FUNC_TICK;
        send_item(it);
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.due.size() != 0) begin
      $display("ERROR: %0d expected beats never arrived", sb.due.size());
      sb.errors++;
    end
    $display("Ran %0d input beats over %0d node setups; beats matched: %0d app, %0d own control,",
             sb.items, setups, sb.kind_seen[KIND_APP], sb.kind_seen[KIND_CTRL]);
    $display("  %0d forwarded control, %0d termination reports",
             sb.kind_seen[KIND_FWD], sb.kind_seen[KIND_TERM]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
